// ===== sv/byte_pattern_replace_stream_defines.svh =====
// Assertion macros for the byte pattern replace stream checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BYTE_PATTERN_REPLACE_STREAM_DEFINES_SVH
`define BYTE_PATTERN_REPLACE_STREAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPRS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bprs_pkg.sv =====
// Shared types, constants and helpers for the byte pattern replace stream.
// No dependencies; used by the window cells, the top level and the checker.
package bprs_pkg;

    localparam int MAX_PATTERN = 6;

    localparam int WORD_W     = 48;
    localparam int WORD_BYTES = WORD_W / 8;
    localparam int LENCFG_W   = 3;
    localparam int IDX_W      = 5;
    localparam int COUNT_W    = 24;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8 + COUNT_W;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 3'd0,
        CFG_PATTERN_LENGTH     = 3'd1,
        CFG_REPLACEMENT_BYTES  = 3'd2,
        CFG_REPLACEMENT_LENGTH = 3'd3,
        CFG_REPLACEMENT_OFFSET = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic app_en;
        logic shift_en;
        logic cmp_en;
        logic patch_en;
    } cell_ctrl_t;

    // Byte idx of a configured word; bytes past the word read as zero.
    function automatic logic [7:0] byte_of(input logic [WORD_W-1:0] word,
                                           input logic [IDX_W-1:0]  idx);
        logic [WORD_W-1:0] sh;
        sh = word >> {idx, 3'b000};
        return (idx < IDX_W'(WORD_BYTES)) ? sh[7:0] : 8'h00;
    endfunction

endpackage

// ===== sv/bprs_cell.sv =====
// One byte position of the compare window: holds a byte, compares it, patches it
// and hands it to its left neighbor on a shift. Depends on bprs_pkg.
module bprs_cell (
    input  logic                   aclk,
    input  bprs_pkg::cell_ctrl_t   ctrl,
    input  logic [7:0]             in_byte,
    input  logic [7:0]             pat_byte,
    input  logic [7:0]             rep_byte,
    input  logic [7:0]             right_byte,
    output logic                   eq,
    output logic [7:0]             patched_byte
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic [7:0] cur_byte;

    assign cur_byte     = ctrl.app_en ? in_byte : byte_reg;
    assign eq           = !ctrl.cmp_en || (cur_byte == pat_byte);
    assign patched_byte = ctrl.patch_en ? rep_byte : cur_byte;
    assign byte_next    = ctrl.shift_en ? right_byte : patched_byte;

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule

// ===== sv/byte_pattern_replace_stream.sv =====
// Channel   Ports                                   Carries
// s_        s_tvalid s_tready s_tdata s_tlast       input bytes, tlast ends the region
// m_        m_tvalid m_tready m_tdata m_tlast       output bytes, tlast on the last one
// cfg_      cfg_valid cfg_ready cfg_index cfg_data  register writes, always ready
//
// With pattern_length bytes held, one byte in and one out per cycle unless m_tready stalls.
// A final transaction flushes the window one byte per cycle unless m_tready stalls,
// with s_tready low meanwhile; a shorter pattern_length drains likewise on the next byte.
// aresetn is synchronous: clears fill, skip, match count and the channel state.
// m_tready low holds the output register; input is still taken until a byte must leave.
// Depends on bprs_pkg and bprs_cell.
module byte_pattern_replace_stream #(
    parameter int MAX_PATTERN = bprs_pkg::MAX_PATTERN
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bprs_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bprs_pkg::M_TDATA_W-1:0]    m_tdata,   // [7:0] out_byte, [31:8] match_total
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bprs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bprs_pkg::WORD_W-1:0]       cfg_data
);

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W  = bprs_pkg::IDX_W;
    localparam int CNT_W  = bprs_pkg::COUNT_W;
    localparam int LCFG_W = bprs_pkg::LENCFG_W;

    // configuration
    logic [bprs_pkg::WORD_W-1:0] pat_reg;
    logic [bprs_pkg::WORD_W-1:0] rep_reg;
    logic [LCFG_W-1:0]           plen_reg;
    logic [LCFG_W-1:0]           rlen_reg;
    logic [LCFG_W-1:0]           roff_reg;

    // control
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [LCFG_W-1:0] skip_reg, skip_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              flush_reg, flush_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_byte_reg;
    logic [CNT_W-1:0]  m_total_reg;
    logic              m_last_reg;

    logic              acc;
    logic              out_free;
    logic              flush_eff;
    logic              active;
    logic [IDX_W-1:0]  len5;
    logic [FILL_W-1:0] len;
    logic [IDX_W-1:0]  off5;
    logic [IDX_W-1:0]  end5;
    logic [FILL_W-1:0] f_app;
    logic              work_now;
    logic              emit;
    logic              do_test;
    logic              match;
    logic              final_emit;
    logic              cnt_inc;
    logic [CNT_W-1:0]  cnt_after;

    logic [MAX_PATTERN-1:0]  eq;
    logic [7:0]              patched [MAX_PATTERN];
    bprs_pkg::cell_ctrl_t    cell_ctrl [MAX_PATTERN];

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign acc       = s_tvalid && !busy_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // effective pattern length: zero counts as one, clamp to the window
    always_comb begin
        if (plen_reg == '0) begin
            len5 = IDX_W'(1);
        end else if (IDX_W'(plen_reg) > IDX_W'(MAX_PATTERN)) begin
            len5 = IDX_W'(MAX_PATTERN);
        end else begin
            len5 = IDX_W'(plen_reg);
        end
    end
    assign len  = FILL_W'(len5);
    assign off5 = IDX_W'(roff_reg);
    assign end5 = IDX_W'(roff_reg) + IDX_W'(rlen_reg);

    assign flush_eff = flush_reg || (acc && s_tlast);
    assign active    = busy_reg || acc;
    assign f_app     = fill_reg + FILL_W'(acc);
    assign work_now  = active && (f_app != '0) && ((f_app >= len) || flush_eff);
    assign emit      = work_now && out_free;
    assign do_test   = emit && (f_app >= len);
    assign match     = do_test && (skip_reg == '0) && (&eq);
    assign final_emit = emit && flush_eff && (f_app == FILL_W'(1));

    assign cnt_inc   = match && (cnt_reg != bprs_pkg::COUNT_MAX);
    assign cnt_after = cnt_reg + CNT_W'(cnt_inc);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
            localparam logic [IDX_W-1:0] POS = IDX_W'(gi);
            logic [7:0] right_byte;

            if (gi == MAX_PATTERN - 1) begin : g_last
                assign right_byte = patched[gi];
            end else begin : g_mid
                assign right_byte = patched[gi + 1];
            end

            assign cell_ctrl[gi] = '{
                app_en:   acc && (fill_reg == FILL_W'(gi)),
                shift_en: emit,
                cmp_en:   POS < len5,
                patch_en: match && (POS >= off5) && (POS < end5) && (POS < len5)
            };

            bprs_cell u_cell (
                .aclk         (aclk),
                .ctrl         (cell_ctrl[gi]),
                .in_byte      (s_tdata[7:0]),
                .pat_byte     (bprs_pkg::byte_of(pat_reg, POS)),
                .rep_byte     (bprs_pkg::byte_of(rep_reg, POS - off5)),
                .right_byte   (right_byte),
                .eq           (eq[gi]),
                .patched_byte (patched[gi])
            );
        end
    endgenerate

    always_comb begin
        fill_next  = f_app - FILL_W'(emit);
        busy_next  = active && (fill_next != '0) && ((fill_next >= len) || flush_eff);
        flush_next = flush_eff && (fill_next != '0);

        skip_next = skip_reg;
        if (final_emit) begin
            skip_next = '0;
        end else if (match) begin
            skip_next = rlen_reg;
        end else if (do_test && (skip_reg != '0)) begin
            skip_next = skip_reg - LCFG_W'(1);
        end

        cnt_next = final_emit ? '0 : cnt_after;

        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            skip_reg     <= '0;
            cnt_reg      <= '0;
            busy_reg     <= 1'b0;
            flush_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            skip_reg     <= skip_next;
            cnt_reg      <= cnt_next;
            busy_reg     <= busy_next;
            flush_reg    <= flush_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_byte_reg  <= patched[0];
            m_last_reg  <= final_emit;
            m_total_reg <= final_emit ? cnt_after : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg  <= '0;
            plen_reg <= LCFG_W'(1);
            rep_reg  <= '0;
            rlen_reg <= '0;
            roff_reg <= '0;
        end else if (cfg_valid) begin
            unique case (bprs_pkg::cfg_reg_t'(cfg_index))
                bprs_pkg::CFG_PATTERN_BYTES:      pat_reg  <= cfg_data;
                bprs_pkg::CFG_PATTERN_LENGTH:     plen_reg <= cfg_data[LCFG_W-1:0];
                bprs_pkg::CFG_REPLACEMENT_BYTES:  rep_reg  <= cfg_data;
                bprs_pkg::CFG_REPLACEMENT_LENGTH: rlen_reg <= cfg_data[LCFG_W-1:0];
                bprs_pkg::CFG_REPLACEMENT_OFFSET: roff_reg <= cfg_data[LCFG_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_total_reg, m_byte_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== sv/bprs_checker.sv =====
// Port-level checks for byte_pattern_replace_stream, bound to the top level.
// Depends on bprs_pkg and byte_pattern_replace_stream_defines.svh.
`include "byte_pattern_replace_stream_defines.svh"

module bprs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bprs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    // hold a stalled output transaction
    `BPRS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

    // match total shows only on the last byte of a region
    `BPRS_ASSERT_NOW(a_total_only_last, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[bprs_pkg::M_TDATA_W-1:8] == '0, "match total on a non-final byte")

    // input only stalls while the window drains through a full output register
    `BPRS_ASSERT_NOW(a_stall_has_output, aclk, aresetn, !s_tready, m_tvalid, "input stalled with no output pending")

endmodule

bind byte_pattern_replace_stream bprs_checker u_bprs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== bench/bprs_replace_monitor.sv =====
// Monitor for byte_pattern_replace_stream: watches the config, input and output channels,
// predicts every output transaction from the accepted input bytes and compares.
// Depends on bprs_pkg.
module bprs_replace_monitor import bprs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,   // [7:0] out_byte, [31:8] match_total
    input  logic                   m_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    output int                     mismatches,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               out_final;
        logic [COUNT_W-1:0] match_total;
    } out_item_t;

    out_item_t          predicted_out[$];

    logic [WORD_W-1:0]  pattern_word;
    logic [WORD_W-1:0]  replace_word;
    logic [2:0]         pattern_len_cfg;
    logic [2:0]         replace_len_cfg;
    logic [2:0]         replace_off_cfg;

    logic [7:0]         held [MAX_PATTERN];
    int                 held_count;
    int                 skips_pending;
    logic [COUNT_W-1:0] hits;

    // Pop the oldest window byte into the prediction queue.
    task automatic shift_out();
        out_item_t item;
        item.out_byte    = held[0];
        item.out_final   = 1'b0;
        item.match_total = '0;
        predicted_out.push_back(item);
        for (int i = 1; i < held_count; i++)
            held[i-1] = held[i];
        held_count--;
    endtask

    task automatic scan_byte(input logic [7:0] data, input logic is_last);
        int        width;
        int        stop;
        logic      hit;
        out_item_t tail;
        width = (pattern_len_cfg == 3'd0) ? 1 :
                ((int'(pattern_len_cfg) > MAX_PATTERN) ? MAX_PATTERN : int'(pattern_len_cfg));
        if (held_count < MAX_PATTERN) begin
            held[held_count] = data;
            held_count++;
        end
        while (held_count >= width) begin
            if (skips_pending > 0) begin
                skips_pending--;
            end else begin
                hit = 1'b1;
                for (int i = 0; i < width; i++)
                    if (held[i] != pattern_word[8*i +: 8])
                        hit = 1'b0;
                if (hit) begin
                    if (hits != COUNT_MAX)
                        hits++;
                    // patch only inside the compared window; skip uses the full length
                    stop = int'(replace_off_cfg) + int'(replace_len_cfg);
                    if (stop > width)
                        stop = width;
                    for (int i = int'(replace_off_cfg); i < stop; i++)
                        held[i] = replace_word[8*(i-int'(replace_off_cfg)) +: 8];
                    skips_pending = int'(replace_len_cfg);
                end
            end
            shift_out();
        end
        if (is_last) begin
            while (held_count > 0)
                shift_out();
            tail = predicted_out.pop_back();
            tail.out_final   = 1'b1;
            tail.match_total = hits;
            predicted_out.push_back(tail);
            skips_pending = 0;
            hits          = '0;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        logic      bad;
        if (!aresetn) begin
            pattern_word    = '0;
            pattern_len_cfg = 3'd1;
            replace_word    = '0;
            replace_len_cfg = 3'd0;
            replace_off_cfg = 3'd0;
            held_count      = 0;
            skips_pending   = 0;
            hits            = '0;
            mismatches      = 0;
            predicted_out.delete();
            outstanding    <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PATTERN_BYTES:      pattern_word    = cfg_data;
                    CFG_PATTERN_LENGTH:     pattern_len_cfg = cfg_data[2:0];
                    CFG_REPLACEMENT_BYTES:  replace_word    = cfg_data;
                    CFG_REPLACEMENT_LENGTH: replace_len_cfg = cfg_data[2:0];
                    CFG_REPLACEMENT_OFFSET: replace_off_cfg = cfg_data[2:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                scan_byte(s_tdata[7:0], s_tlast);
            if (m_tvalid && m_tready) begin
                if (predicted_out.size() == 0) begin
                    $display("%0t: unexpected output, expected none, got byte %h last %b total %0d",
                             $time, m_tdata[7:0], m_tlast, m_tdata[31:8]);
                    mismatches++;
                end else begin
                    want = predicted_out.pop_front();
                    bad  = 1'b0;
                    if (m_tdata[7:0] !== want.out_byte) begin
                        $display("%0t: out_byte expected %h got %h",
                                 $time, want.out_byte, m_tdata[7:0]);
                        bad = 1'b1;
                    end
                    if (m_tlast !== want.out_final) begin
                        $display("%0t: out_final expected %b got %b",
                                 $time, want.out_final, m_tlast);
                        bad = 1'b1;
                    end
                    if (m_tdata[31:8] !== want.match_total) begin
                        $display("%0t: match_total expected %0d got %0d",
                                 $time, want.match_total, m_tdata[31:8]);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches++;
                end
            end
            outstanding <= predicted_out.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// Top of the byte_pattern_replace_stream bench: clock, reset, register programming and
// byte stimulus with random idling on both channels. Depends on bprs_pkg, the block and
// bprs_replace_monitor, which does all prediction and comparison.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bprs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 20;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [7:0] data_byte
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // [7:0] out_byte, [31:8] match_total
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    int                   mismatches;
    int                   outstanding;
    int                   cycles = 0;
    int                   src_idle_pct = 0;
    int                   sink_idle_pct = 0;

    // stimulus-side copy of the pattern, used only to shape the byte stream
    logic [WORD_W-1:0]    cur_pattern = '0;
    logic [2:0]           cur_length = 3'd1;

    byte_pattern_replace_stream DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bprs_replace_monitor u_monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[byte_pattern_replace_stream] ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid, drain every predicted output, then let a flush in progress finish.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [WORD_W-1:0] pat, input logic [WORD_W-1:0] plen,
                                input logic [WORD_W-1:0] rep, input logic [WORD_W-1:0] rlen,
                                input logic [WORD_W-1:0] roff);
        cfg_reg_t          reg_order[5] = '{CFG_PATTERN_BYTES, CFG_PATTERN_LENGTH,
                                            CFG_REPLACEMENT_BYTES, CFG_REPLACEMENT_LENGTH,
                                            CFG_REPLACEMENT_OFFSET};
        logic [WORD_W-1:0] vals[5];
        vals = '{pat, plen, rep, rlen, roff};
        for (int k = 0; k < 5; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_order[k];
            cfg_data  <= vals[k];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid   <= 1'b0;
        cur_pattern  = pat;
        cur_length   = plen[2:0];
    endtask

    // Draw pattern and replacement from a tiny alphabet so matches overlap and patches
    // can create or destroy later matches.
    task automatic random_config();
        logic [7:0]        alphabet[3];
        logic [WORD_W-1:0] pat;
        logic [WORD_W-1:0] rep;
        logic [WORD_W-1:0] plen;
        logic [WORD_W-1:0] rlen;
        logic [WORD_W-1:0] roff;
        for (int k = 0; k < 3; k++)
            alphabet[k] = 8'($urandom_range(0, 255));
        for (int i = 0; i < WORD_BYTES; i++) begin
            pat[8*i +: 8] = ($urandom_range(0, 3) != 0) ? alphabet[$urandom_range(0, 2)]
                                                        : 8'($urandom_range(0, 255));
            rep[8*i +: 8] = ($urandom_range(0, 3) != 0) ? alphabet[$urandom_range(0, 2)]
                                                        : 8'($urandom_range(0, 255));
        end
        plen = WORD_W'($urandom_range(1, MAX_PATTERN));
        rlen = WORD_W'($urandom_range(0, MAX_PATTERN));
        roff = WORD_W'($urandom_range(0, MAX_PATTERN - 1));
        // junk above the register width must be ignored
        if ($urandom_range(0, 5) == 0)
            plen[WORD_W-1:3] = (WORD_W-3)'({$urandom(), $urandom()});
        if ($urandom_range(0, 5) == 0)
            rlen[WORD_W-1:3] = (WORD_W-3)'({$urandom(), $urandom()});
        program_regs(pat, plen, rep, rlen, roff);
    endtask

    // Whole or lightly corrupted copies of the pattern, single pattern bytes and some noise.
    task automatic send_region(input int count, input logic closed);
        logic [7:0] stream[$];
        int         plen;
        int         pick;
        plen = (cur_length == 3'd0) ? 1 :
               ((int'(cur_length) > MAX_PATTERN) ? MAX_PATTERN : int'(cur_length));
        while (stream.size() < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                for (int i = 0; i < plen; i++)
                    stream.push_back(cur_pattern[8*i +: 8]);
                if (pick == 0)
                    stream[stream.size() - 1 - $urandom_range(0, plen - 1)] =
                        8'($urandom_range(0, 255));
            end else if (pick < 7) begin
                stream.push_back(cur_pattern[8*$urandom_range(0, WORD_BYTES - 1) +: 8]);
            end else begin
                stream.push_back(8'($urandom_range(0, 255)));
            end
        end
        while (stream.size() > count)
            void'(stream.pop_back());
        for (int i = 0; i < count; i++)
            send_byte(stream[i], closed && (i == count - 1));
    endtask

    initial begin
        int   sent;
        int   n;
        logic closed;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_PATTERN_BYTES;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: one-byte zero pattern, nothing replaced
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // longest pattern of all ones, full-width zero replacement, skip of six
        wait_idle();
        program_regs({WORD_W{1'b1}}, 6, '0, 6, 0);
        for (int i = 0; i < 8; i++)
            send_byte(8'hFF, i == 7);

        // offset past the window: count the match, write nothing, still skip
        wait_idle();
        program_regs(48'h0000_00EF_CDAB, 3, 48'h0000_0033_2211, 3, 5);
        send_byte(8'hAB, 1'b0);
        send_byte(8'hCD, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'hCD, 1'b0);
        send_byte(8'hEF, 1'b1);

        // zero length taken as one, junk upper bits, overlong replacement and offset
        wait_idle();
        program_regs(48'h0000_0000_005A, 48'hFFFF_FFFF_FFF8, {WORD_W{1'b1}},
                     48'hABCD_EF01_2347, 48'h0000_0000_000F);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h5A, 1'b1);

        // length above the maximum, then shortened with bytes held in the window
        wait_idle();
        program_regs(48'h6655_4433_2211, 7, 48'h0000_0000_BBAA, 2, 1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
        wait_idle();
        program_regs(48'h6655_4433_2211, 2, 48'h0000_0000_BBAA, 2, 1);
        send_byte(8'h55, 1'b0);
        send_byte(8'h66, 1'b1);

        for (int seg = 0; seg < 12; seg++) begin
            src_idle_pct  = (seg < 4) ? 27 : ((seg < 8) ? 85 : 0);
            sink_idle_pct = (seg < 4) ? 85 : ((seg < 8) ? 27 : 0);
            wait_idle();
            random_config();
            sent = 0;
            while (sent < 36) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                // sometimes leave the region open so the next settings apply mid-stream
                closed = (sent + n < 36) || (seg == 11) || ($urandom_range(0, 4) != 0);
                send_region(n, closed);
                sent += n;
            end
        end

        wait_idle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("[byte_pattern_replace_stream] OK");
        end else begin
            $display("[byte_pattern_replace_stream] ERROR");
        end
        $finish;
    end

endmodule
